// File: hw/rtl/cddas_pkg.sv
// Shared types, constants and calendar functions for the date arithmetic engine.
// No dependencies; imported by calendar_date_difference_and_subtract.
package cddas_pkg;

	// Operation codes carried in the op field.
	localparam logic OP_DIFF = 1'b0;
	localparam logic OP_SUB  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_BAD_DATE  = 2'd1,
		ERR_UNDERFLOW = 2'd2
	} err_t;

	// Largest year accepted as a valid input date.
	localparam int unsigned YEAR_LIMIT = 9999;

	// Calendar constants.
	localparam int unsigned MONTHS        = 12;
	localparam int unsigned DAYS_PER_YEAR = 365;

	// Division by 100 through a reciprocal: q = (y * RECIP_100) >> RECIP_SHIFT,
	// exact for every y below 43690, which covers the 14-bit year range.
	localparam int unsigned RECIP_100   = 5243;
	localparam int unsigned RECIP_SHIFT = 19;

	// Length of month m (1 = January); zero for codes that are not months.
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the months before month m of a common year.
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] sum;
		case (m)
			4'd2:    sum = 9'd31;
			4'd3:    sum = 9'd59;
			4'd4:    sum = 9'd90;
			4'd5:    sum = 9'd120;
			4'd6:    sum = 9'd151;
			4'd7:    sum = 9'd181;
			4'd8:    sum = 9'd212;
			4'd9:    sum = 9'd243;
			4'd10:   sum = 9'd273;
			4'd11:   sum = 9'd304;
			4'd12:   sum = 9'd334;
			default: sum = 9'd0;
		endcase
		return sum;
	endfunction

endpackage

// File: hw/rtl/calendar_date_difference_and_subtract.sv
// Gregorian date arithmetic engine: date difference and day-count subtraction.
// Depends on cddas_pkg for codes, constants and month tables.
//
// Usage:
// The input channel (in_valid / in_stall) takes one word holding an op code,
// two dates and a day count. The output channel (out_valid / out_stall)
// returns one word per input word: a signed day difference for a difference
// request, or the earlier date for a subtract request, plus a status code.
// Only one word is worked on at a time; in_stall is high from acceptance
// until the result has been moved into the output register.
// Steps: a difference runs two passes of multiply by the reciprocal of 100,
// leap and range check, multiply by 365 and accumulate, then the output load.
// A subtract runs a multiply by the reciprocal of 100 and the leap and range
// check, then one walk step per month walked back and a final partial month,
// then the output load. The next word is taken in the cycle after the result
// is loaded.
// The output register lets a new word be accepted while the last result
// waits; if the receiver still stalls when the next result is ready, the
// sequencer holds in its final state. Reset clears the sequencer and the
// output valid flag; no word is in flight afterwards.
module calendar_date_difference_and_subtract
	import cddas_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [4:0]         first_day,
	input  logic [3:0]         first_month,
	input  logic [13:0]        first_year,
	input  logic [4:0]         second_day,
	input  logic [3:0]         second_month,
	input  logic [13:0]        second_year,
	input  logic [15:0]        day_count,
	// Output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [22:0] difference,
	output logic [4:0]         result_day,
	output logic [3:0]         result_month,
	output logic [13:0]        result_year,
	output logic [1:0]         error_code
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LEAP,
		ST_ACC,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t      state_q;
	logic        op_q;
	logic        sel_q;
	logic [4:0]  d_q;
	logic [3:0]  m_q;
	logic [13:0] y_q;
	logic [4:0]  d2_q;
	logic [3:0]  m2_q;
	logic [13:0] y2_q;
	logic [15:0] cnt_q;
	logic [26:0] prod_q;
	logic [13:0] lcnt_q;
	logic [8:0]  off_q;
	logic [22:0] dn1_q;
	logic [22:0] diff_q;
	logic [6:0]  mod100_q;
	logic [8:0]  mod400_q;
	err_t        err_q;

	logic               out_valid_q;
	logic signed [22:0] difference_q;
	logic [4:0]         result_day_q;
	logic [3:0]         result_month_q;
	logic [13:0]        result_year_q;
	logic [1:0]         error_code_q;

	// Date currently being converted: first date, then the second one.
	logic [4:0]  cur_d;
	logic [3:0]  cur_m;
	logic [13:0] cur_y;

	assign cur_d = sel_q ? d2_q : d_q;
	assign cur_m = sel_q ? m2_q : m_q;
	assign cur_y = sel_q ? y2_q : y_q;

	// Shared multiplier: year times the reciprocal of 100, or year times 365.
	logic [12:0] mul_b;
	logic [26:0] mul_p;

	assign mul_b = (state_q == ST_MUL) ? 13'(RECIP_100) : 13'(DAYS_PER_YEAR);
	assign mul_p = {13'b0, cur_y} * {14'b0, mul_b};

	// Century split of the year and the leap-year count before it.
	logic [7:0]  q100;
	logic [14:0] h100;
	logic [6:0]  m100;
	logic        z100;
	logic        z400;
	logic        leap_c;
	logic [8:0]  mod400_c;
	logic [13:0] yr_m1;
	logic [13:0] lcnt_c;
	logic [4:0]  mlen_c;
	logic        valid_c;
	logic [8:0]  off_c;
	logic [13:0] m100_w;

	assign q100     = prod_q[RECIP_SHIFT +: 8];
	assign h100     = {7'b0, q100} * 15'd100;
	assign m100_w   = cur_y - h100[13:0];
	assign m100     = m100_w[6:0];
	assign z100     = (m100 == 7'd0);
	assign z400     = z100 && (q100[1:0] == 2'b00);
	assign leap_c   = ((cur_y[1:0] == 2'b00) && !z100) || z400;
	assign mod400_c = {7'b0, q100[1:0]} * 9'd100 + {2'b0, m100};
	assign yr_m1    = cur_y - 14'd1;
	assign lcnt_c   = {2'b0, yr_m1[13:2]} - ({6'b0, q100} - {13'b0, z100})
		+ ({8'b0, q100[7:2]} - {13'b0, z400});
	assign mlen_c   = month_len(cur_m, leap_c);
	assign valid_c  = (cur_y != 14'd0) && (32'(cur_y) <= YEAR_LIMIT)
		&& (cur_m != 4'd0) && (32'(cur_m) <= MONTHS)
		&& (cur_d != 5'd0) && (cur_d <= mlen_c);
	assign off_c    = days_before(cur_m) + {8'b0, leap_c && (cur_m > 4'd2)}
		+ {4'b0, cur_d};

	// Day number of the current date.
	logic [22:0] dn_c;

	assign dn_c = prod_q[22:0] + {9'b0, lcnt_q} + {14'b0, off_q};

	// Month walk: leap flag of the walking year and the month before this one.
	logic       leap_w;
	logic [3:0] m_prev;

	assign leap_w = ((y_q[1:0] == 2'b00) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
	assign m_prev = m_q - 4'd1;

	logic out_take;
	logic out_load;

	assign out_take = out_valid_q && !out_stall;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_LEAP;
				end
				ST_LEAP: begin
					if (!valid_c) begin
						state_q <= ST_DONE;
					end else if (op_q == OP_SUB) begin
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					state_q <= sel_q ? ST_DONE : ST_MUL;
				end
				ST_WALK: begin
					if (cnt_q == 16'd0) begin
						state_q <= ST_DONE;
					end else if (({11'b0, d_q} <= cnt_q) && (m_q == 4'd1)
						&& (y_q == 14'd1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the shared unit.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q  <= op;
				sel_q <= 1'b0;
				d_q   <= first_day;
				m_q   <= first_month;
				y_q   <= first_year;
				d2_q  <= second_day;
				m2_q  <= second_month;
				y2_q  <= second_year;
				cnt_q <= day_count;
				err_q <= ERR_NONE;
			end
			ST_MUL: begin
				prod_q <= mul_p;
			end
			ST_LEAP: begin
				prod_q   <= mul_p;
				lcnt_q   <= lcnt_c;
				off_q    <= off_c;
				mod100_q <= m100;
				mod400_q <= mod400_c;
				if (!valid_c) begin
					err_q <= ERR_BAD_DATE;
				end
			end
			ST_ACC: begin
				if (sel_q) begin
					diff_q <= dn1_q - dn_c;
				end else begin
					dn1_q <= dn_c;
					sel_q <= 1'b1;
				end
			end
			ST_WALK: begin
				if (cnt_q != 16'd0) begin
					if ({11'b0, d_q} > cnt_q) begin
						d_q   <= d_q - cnt_q[4:0];
						cnt_q <= 16'd0;
					end else begin
						cnt_q <= cnt_q - {11'b0, d_q};
						if (m_q == 4'd1) begin
							// Year boundary: December of the previous year.
							m_q      <= 4'd12;
							y_q      <= y_q - 14'd1;
							d_q      <= 5'd31;
							mod100_q <= (mod100_q == 7'd0) ? 7'd99 : mod100_q - 7'd1;
							mod400_q <= (mod400_q == 9'd0) ? 9'd399 : mod400_q - 9'd1;
							if (y_q == 14'd1) begin
								err_q <= ERR_UNDERFLOW;
							end
						end else begin
							m_q <= m_prev;
							d_q <= month_len(m_prev, leap_w);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output payload, zeroed where the op or an error leaves a field unused.
	always_ff @(posedge clk) begin
		if (out_load) begin
			error_code_q <= err_q;
			if (err_q == ERR_NONE && op_q == OP_DIFF) begin
				difference_q <= diff_q;
			end else begin
				difference_q <= '0;
			end
			if (err_q == ERR_NONE && op_q == OP_SUB) begin
				result_day_q   <= d_q;
				result_month_q <= m_q;
				result_year_q  <= y_q;
			end else begin
				result_day_q   <= '0;
				result_month_q <= '0;
				result_year_q  <= '0;
			end
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign difference   = difference_q;
	assign result_day   = result_day_q;
	assign result_month = result_month_q;
	assign result_year  = result_year_q;
	assign error_code   = error_code_q;

	// A failed request carries nothing but its status code.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code != ERR_NONE) |->
			(difference == 23'sd0) && (result_month == 4'd0) && (result_year == 14'd0))
		else $error("error word carries payload");

	// A word never holds both a difference and a date.
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (difference == 23'sd0) || (result_month == 4'd0))
		else $error("difference and date both present");

	// The walk keeps a real month and a nonzero day.
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (m_q != 4'd0) && (m_q <= 4'd12) && (d_q != 5'd0))
		else $error("walk left the calendar");

	// A finished result waits while the output register is still full.
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_valid_q && out_stall |=> (state_q == ST_DONE))
		else $error("result dropped under stall");

	// A new result is loaded only when the output register is free or draining.
	a_load_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || !out_stall)
		else $error("output overwritten");

endmodule
